FILE: hw/rtl/dtq_pkg.sv
// shared types and constants for the deadline timer queue
// no dependencies
`timescale 1ns / 1ps

package dtq_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int ID_BITS     = 16;
    localparam int TIME_W      = 48;
    localparam int DELAY_W     = 32;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W     = TIME_W + ID_BITS;
    localparam int IN_DATA_W   = 96;
    localparam int OUT_DATA_W  = 72;

    localparam logic [1:0] KIND_ACK  = 2'd0;
    localparam logic [1:0] KIND_FIRE = 2'd1;
    localparam logic [1:0] KIND_WAIT = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD_CHK,
        ST_ADD_CMP,
        ST_ADD_ACK,
        ST_TICK_CHK,
        ST_TICK_CMP
    } state_t;

    typedef struct packed {
        logic load;
        logic rd_prev;
        logic rd_head;
        logic wr_shift;
        logic wr_new;
        logic emit_full;
        logic emit_ack;
        logic emit_fire;
        logic emit_wait;
        logic emit_empty;
    } cmd_t;

    typedef struct packed {
        logic action;
        logic full;
        logic cnt_zero;
        logic pos_zero;
        logic prev_gt;
        logic head_le;
        logic out_free;
    } status_t;

endpackage

FILE: hw/rtl/dtq_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module dtq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hw/rtl/dtq_ctrl.sv
// controller state machine for the deadline timer queue
// depends on dtq_pkg
`timescale 1ns / 1ps

module dtq_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  dtq_pkg::status_t st,
    output dtq_pkg::cmd_t    cmd
);

    import dtq_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = st.action ? ST_TICK_CHK : ST_ADD_CHK;
                end
            end
            ST_ADD_CHK:
            begin
                if (st.full)
                begin
                    if (st.out_free)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (st.pos_zero)
                begin
                    state_next = ST_ADD_ACK;
                end
                else
                begin
                    state_next = ST_ADD_CMP;
                end
            end
            ST_ADD_CMP:
            begin
                state_next = st.prev_gt ? ST_ADD_CHK : ST_ADD_ACK;
            end
            ST_ADD_ACK:
            begin
                if (st.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_TICK_CHK:
            begin
                if (st.cnt_zero)
                begin
                    if (st.out_free)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_TICK_CMP;
                end
            end
            ST_TICK_CMP:
            begin
                if (st.out_free)
                begin
                    state_next = st.head_le ? ST_TICK_CHK : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_ADD_CHK:
            begin
                if (st.full)
                begin
                    cmd.emit_full = st.out_free;
                end
                else if (st.pos_zero)
                begin
                    cmd.wr_new = 1'b1;
                end
                else
                begin
                    cmd.rd_prev = 1'b1;
                end
            end
            ST_ADD_CMP:
            begin
                cmd.wr_shift = st.prev_gt;
                cmd.wr_new   = !st.prev_gt;
            end
            ST_ADD_ACK:
            begin
                cmd.emit_ack = st.out_free;
            end
            ST_TICK_CHK:
            begin
                if (st.cnt_zero)
                begin
                    cmd.emit_empty = st.out_free;
                end
                else
                begin
                    cmd.rd_head = 1'b1;
                end
            end
            ST_TICK_CMP:
            begin
                cmd.emit_fire = st.out_free && st.head_le;
                cmd.emit_wait = st.out_free && !st.head_le;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: hw/rtl/dtq_dp.sv
// datapath: circular sorted entry store, insert pointer, output register
// depends on dtq_pkg and dtq_ram
`timescale 1ns / 1ps

module dtq_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  dtq_pkg::cmd_t                        cmd,
    output dtq_pkg::status_t                     st,
    input  logic [dtq_pkg::IN_DATA_W-1:0]        s_tdata,
    input  logic                                 s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [dtq_pkg::OUT_DATA_W-1:0]       m_tdata,
    output logic [1:0]                           m_tuser,
    output logic                                 m_tlast
);

    import dtq_pkg::*;

    logic [PTR_W-1:0]  head_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [PTR_W-1:0]  pos_reg;
    logic [TIME_W-1:0] now_reg;
    logic [TIME_W-1:0] dl_reg;
    logic [ID_BITS-1:0] id_reg;

    logic              out_valid_reg;
    logic [1:0]        out_kind_reg;
    logic [15:0]       out_id_reg;
    logic [TIME_W-1:0] out_wait_reg;
    logic              out_full_reg;
    logic              out_last_reg;

    logic [TIME_W:0]   sum;
    logic [TIME_W-1:0] dl_sat;
    logic              we, re;
    logic [PTR_W-1:0]  waddr, raddr;
    logic [ENTRY_W-1:0] wdata, rdata;
    logic [TIME_W-1:0] rd_dl;
    logic [ID_BITS-1:0] rd_id;
    logic [PTR_W-1:0]  pos_m1;

    function automatic logic [PTR_W-1:0] phys(input logic [PTR_W-1:0] base,
                                              input logic [PTR_W-1:0] idx);
        logic [PTR_W:0] s;
        s = {1'b0, base} + {1'b0, idx};
        if (s >= (PTR_W+1)'(QUEUE_DEPTH))
        begin
            s = s - (PTR_W+1)'(QUEUE_DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

    // now_us bits 47:0, delay_us 79:48, task_id 95:80
    assign sum    = {1'b0, s_tdata[TIME_W-1:0]}
                  + (TIME_W+1)'(s_tdata[TIME_W+DELAY_W-1:TIME_W]);
    assign dl_sat = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];

    assign rd_dl  = rdata[ENTRY_W-1:ID_BITS];
    assign rd_id  = rdata[ID_BITS-1:0];
    assign pos_m1 = pos_reg - PTR_W'(1);

    assign re    = cmd.rd_prev || cmd.rd_head;
    assign raddr = cmd.rd_head ? head_reg : phys(head_reg, pos_m1);
    assign we    = cmd.wr_shift || cmd.wr_new;
    assign waddr = phys(head_reg, pos_reg);
    assign wdata = cmd.wr_shift ? rdata : {dl_reg, id_reg};

    dtq_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_store (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .re   (re),
        .raddr(raddr),
        .rdata(rdata)
    );

    always_comb
    begin
        // action is only looked at while the input word is offered
        st.action   = s_tuser;
        st.full     = (count_reg == CNT_W'(QUEUE_DEPTH));
        st.cnt_zero = (count_reg == '0);
        st.pos_zero = (pos_reg == '0);
        st.prev_gt  = (rd_dl > dl_reg);
        st.head_le  = (rd_dl <= now_reg);
        st.out_free = !out_valid_reg || m_tready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (cmd.wr_new)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (cmd.emit_fire)
            begin
                count_reg <= count_reg - CNT_W'(1);
                head_reg  <= phys(head_reg, PTR_W'(1));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            now_reg    <= s_tdata[TIME_W-1:0];
            dl_reg     <= dl_sat;
            id_reg     <= s_tdata[TIME_W+DELAY_W+ID_BITS-1:TIME_W+DELAY_W];
            pos_reg    <= count_reg[PTR_W-1:0];
        end
        else if (cmd.wr_shift)
        begin
            pos_reg <= pos_m1;
        end
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_full || cmd.emit_ack || cmd.emit_fire
                 || cmd.emit_wait || cmd.emit_empty)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_full || cmd.emit_ack || cmd.emit_fire
            || cmd.emit_wait || cmd.emit_empty)
        begin
            out_kind_reg <= cmd.emit_fire ? KIND_FIRE
                          : ((cmd.emit_wait || cmd.emit_empty) ? KIND_WAIT : KIND_ACK);
            out_id_reg   <= cmd.emit_fire ? 16'(rd_id) : 16'd0;
            out_wait_reg <= cmd.emit_wait ? (rd_dl - now_reg) : '0;
            out_full_reg <= cmd.emit_full;
            out_last_reg <= !cmd.emit_fire;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_full_reg, out_wait_reg, out_id_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

FILE: hw/rtl/deadline_timer_queue.sv
// deadline timer queue: sorted circular store of deadlines with task ids
// add: shifts each later-deadline entry up, writes the new one; full sets full_res
// tick: one fire word per due entry, then a closing wait word
// one item at a time; the store ram's single read port sets the step rate
// reset empties the queue at once; store contents need no clearing
`timescale 1ns / 1ps

module deadline_timer_queue (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [dtq_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // now_us, delay_us, task_id
    input  logic                            s_axis_tuser,  // action
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [dtq_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // fired_id, wait_us, full_res
    output logic [1:0]                      m_axis_tuser,  // kind
    output logic                            m_axis_tlast
);

    import dtq_pkg::*;

    cmd_t    cmd;
    status_t st;

    dtq_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(s_axis_tvalid),
        .in_ready(s_axis_tready),
        .st      (st),
        .cmd     (cmd)
    );

    dtq_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .st      (st),
        .s_tdata (s_axis_tdata),
        .s_tuser (s_axis_tuser),
        .m_tvalid(m_axis_tvalid),
        .m_tready(m_axis_tready),
        .m_tdata (m_axis_tdata),
        .m_tuser (m_axis_tuser),
        .m_tlast (m_axis_tlast)
    );

endmodule

FILE: sim/deadline_timer_queue_tb.sv
// testbench for the deadline timer queue: directed and random adds and ticks
// depends on dtq_pkg and deadline_timer_queue; predicts results from a sorted copy of the queue
`timescale 1ns / 1ps

module deadline_timer_queue_tb;
    import dtq_pkg::*;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] fired_id;
        logic [47:0] wait_us;
        logic        full_res;
        logic        last;
    } timer_word_t;

    localparam logic ACT_ADD  = 1'b0;
    localparam logic ACT_TICK = 1'b1;
    localparam longint CYCLE_LIMIT = 3000000;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata;
    logic s_axis_tuser;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [1:0] m_axis_tuser;
    logic m_axis_tlast;

    deadline_timer_queue DUT (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    // predicted queue contents, kept in release order
    logic [47:0] pend_deadline[$];
    logic [15:0] pend_id[$];
    timer_word_t expected_words[$];

    int  errors = 0;
    int  words_seen = 0;
    int  fires_seen = 0;
    int  fulls_seen = 0;
    int  items_sent = 0;
    bit  hold_rx = 0;
    bit  rx_idle_on = 1;
    longint cycles = 0;
    logic [47:0] clock_us = 0;

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("timeout at %0t", $time);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    function automatic void predict_item(logic act, logic [47:0] now,
                                         logic [31:0] delay, logic [15:0] id);
        timer_word_t w;
        logic [48:0] sum;
        logic [47:0] dl;
        int pos;
        w = '0;
        if (act == ACT_ADD)
        begin
            w.kind = KIND_ACK;
            w.last = 1'b1;
            if (pend_deadline.size() >= QUEUE_DEPTH)
                w.full_res = 1'b1;
            else
            begin
                sum = {1'b0, now} + {17'd0, delay};
                dl = sum[48] ? {48{1'b1}} : sum[47:0];
                pos = pend_deadline.size();
                while (pos > 0 && pend_deadline[pos-1] > dl)
                    pos--;
                pend_deadline.insert(pos, dl);
                pend_id.insert(pos, id);
            end
            expected_words.push_back(w);
        end
        else
        begin
            while (pend_deadline.size() > 0 && pend_deadline[0] <= now)
            begin
                w = '0;
                w.kind = KIND_FIRE;
                w.fired_id = pend_id.pop_front();
                void'(pend_deadline.pop_front());
                expected_words.push_back(w);
            end
            w = '0;
            w.kind = KIND_WAIT;
            w.last = 1'b1;
            if (pend_deadline.size() > 0)
                w.wait_us = pend_deadline[0] - now;
            expected_words.push_back(w);
        end
    endfunction

    // valid stays high between back to back words; dropped only before a gap
    task automatic send_timer_item(logic act, logic [47:0] now,
                                   logic [31:0] delay, logic [15:0] id, int gap);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {id, delay, now};
        do @(posedge clk); while (!s_axis_tready);
        predict_item(act, now, delay, id);
        items_sent++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // receiver: random stalls plus a long forced hold
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_rx)
                m_axis_tready <= 1'b0;
            else if (rx_idle_on && pick_gap() > 0)
                m_axis_tready <= 1'b0;
            else
                m_axis_tready <= 1'b1;
        end
    end

    // result checker
    initial
    begin
        timer_word_t got, exp;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                got.kind = m_axis_tuser;
                got.fired_id = m_axis_tdata[15:0];
                got.wait_us = m_axis_tdata[63:16];
                got.full_res = m_axis_tdata[64];
                got.last = m_axis_tlast;
                words_seen++;
                if (got.kind == KIND_FIRE) fires_seen++;
                if (got.full_res) fulls_seen++;
                if (expected_words.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected word kind=%0d id=%0h wait=%0h %s%0b last=%0b",
                             $time, got.kind, got.fired_id, got.wait_us, "full=",
                             got.full_res, got.last);
                end
                else
                begin
                    exp = expected_words.pop_front();
                    if (got !== exp)
                    begin
                        errors++;
                        $display("%0t: mismatch expected kind=%0d id=%0h wait=%0h %s%0b %s%0b",
                                 $time, exp.kind, exp.fired_id, exp.wait_us,
                                 "full=", exp.full_res, "last=", exp.last);
                        $display("%0t:          actual kind=%0d id=%0h wait=%0h %s%0b %s%0b",
                                 $time, got.kind, got.fired_id, got.wait_us,
                                 "full=", got.full_res, "last=", got.last);
                    end
                end
            end
        end
    end

    task automatic arm_timer(logic [31:0] delay, logic [15:0] id);
        send_timer_item(ACT_ADD, clock_us, delay, id, pick_gap());
    endtask

    task automatic tick_at(logic [47:0] now);
        clock_us = now;
        send_timer_item(ACT_TICK, now, $urandom(), 16'($urandom()), pick_gap());
    endtask

    task automatic test_directed();
        tick_at(48'd0);
        arm_timer(32'd10, 16'hFFFF);
        arm_timer(32'd10, 16'h0000);
        arm_timer(32'd5, 16'h1234);
        arm_timer(32'd0, 16'hA5A5);
        tick_at(48'd5);
        tick_at(48'd10);
        clock_us = 48'hFFFF_FFFF_FF00;
        arm_timer(32'hFFFF_FFFF, 16'h5A5A);
        arm_timer(32'h0000_00FF, 16'h0F0F);
        tick_at(48'hFFFF_FFFF_FFFE);
        tick_at(48'hFFFF_FFFF_FFFF);
        clock_us = 48'd0;
        arm_timer(32'h8000_0000, 16'h00F0);
        tick_at(48'h0000_7FFF_FFFF);
        tick_at(48'h1_0000_0000);
    endtask

    // fill beyond depth while the receiver holds off
    task automatic test_fill_and_stall();
        clock_us = 48'd1000;
        fork
            begin
                hold_rx = 1;
                repeat (300) @(posedge clk);
                hold_rx = 0;
            end
            for (int i = 0; i < QUEUE_DEPTH + 4; i++)
                send_timer_item(ACT_ADD, clock_us, $urandom_range(0, 20),
                                16'($urandom()), 0);
        join
        tick_at(48'd1010);
        tick_at(48'hFFFF_FFFF_FFFF);
    endtask

    task automatic test_random(int count);
        logic [31:0] d;
        int r;
        clock_us = 48'({$urandom(), $urandom()}) & 48'h0FFF_FFFF_FFFF;
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 2) rx_idle_on = 0;
            if (i == count * 3 / 4) rx_idle_on = 1;
            r = $urandom_range(0, 99);
            if (r < 60)
            begin
                case ($urandom_range(0, 5))
                    0: d = $urandom();
                    1: d = 32'hFFFF_FFFF;
                    default: d = $urandom_range(0, 200);
                endcase
                if ($urandom_range(0, 30) == 0)
                    clock_us = 48'({$urandom(), $urandom()});
                arm_timer(d, 16'($urandom()));
            end
            else if (r < 95)
                tick_at(clock_us + $urandom_range(0, 120));
            else
                tick_at(48'({$urandom(), $urandom()}));
        end
    endtask

    initial
    begin
        rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        s_axis_tuser = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        test_directed();
        test_fill_and_stall();
        test_random(358);
        s_axis_tvalid <= 1'b0;
        while (expected_words.size() > 0) @(posedge clk);
        repeat (100) @(posedge clk);
        $display("sent %0d items; checked %0d words, %0d fired, %0d full drops",
                 items_sent, words_seen, fires_seen, fulls_seen);
        if (errors == 0 && expected_words.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
